>>> hw/rtl/fully_connected_matvec_macros.svh
// assertion macros for the fully connected matrix-vector block
// expects clk and rst_n in the scope of every use
`ifndef FULLY_CONNECTED_MATVEC_MACROS_SVH
`define FULLY_CONNECTED_MATVEC_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FCMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fcmv_pkg.sv
// shared types and constants of the fully connected matrix-vector block
// no dependencies
`timescale 1ns / 1ps

package fcmv_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        act_index;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } result_t;

    // control of the weight in the read stage
    typedef struct packed {
        logic             valid;
        logic             eor;
        logic [IDX_W-1:0] out_index;
        logic             last;
    } stage_t;

endpackage

>>> hw/rtl/fcmv_act_mem.sv
// activation store: one write port, one registered read port
// depends on fcmv_pkg
`timescale 1ns / 1ps

module fcmv_act_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [fcmv_pkg::VAL_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [fcmv_pkg::VAL_W-1:0] rd_data
);

    logic signed [fcmv_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [fcmv_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/fcmv_seq.sv
// front end: length registers, column and row counters, read stage
// depends on fcmv_pkg
`timescale 1ns / 1ps

module fcmv_seq #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 1024,
    localparam int AW = $clog2(MAX_INPUTS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_stall,
    input  fcmv_pkg::item_t                      item,
    input  logic                                 cfg_we,
    input  logic [fcmv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcmv_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 hold,
    output logic                                 restart,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic signed [fcmv_pkg::VAL_W-1:0]    wr_data,
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_addr,
    output fcmv_pkg::stage_t                     stage,
    output logic signed [fcmv_pkg::VAL_W-1:0]    weight
);

    localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    // clamped length minus one
    function automatic logic [AW-1:0] in_limit(input logic [fcmv_pkg::CFG_W-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_INPUTS)
        begin
            n = MAX_INPUTS;
        end
        return AW'(n - 1);
    endfunction

    function automatic logic [RW-1:0] out_limit(input logic [fcmv_pkg::CFG_W-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_OUTPUTS)
        begin
            n = MAX_OUTPUTS;
        end
        return RW'(n - 1);
    endfunction

    logic [AW-1:0] in_lim_reg, in_lim_next;
    logic [RW-1:0] out_lim_reg, out_lim_next;
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    fcmv_pkg::stage_t stage_reg, stage_next;
    logic signed [fcmv_pkg::VAL_W-1:0] weight_reg, weight_next;

    logic item_acc;
    logic w_acc;
    logic eor;
    logic last_row;

    assign item_acc = item_valid && !item_stall;
    assign w_acc    = item_acc && item.kind;
    assign eor      = (col_reg == in_lim_reg);
    assign last_row = (row_reg == out_lim_reg);
    assign restart  = cfg_we && ((cfg_index == fcmv_pkg::REG_INPUT_LENGTH) ||
                                 (cfg_index == fcmv_pkg::REG_OUTPUT_LENGTH));

    assign wr_en   = item_acc && !item.kind && (32'(item.act_index) < MAX_INPUTS);
    assign wr_addr = AW'(item.act_index);
    assign wr_data = item.value;
    assign rd_en   = w_acc;
    assign rd_addr = col_reg;

    always_comb
    begin
        in_lim_next  = in_lim_reg;
        out_lim_next = out_lim_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        stage_next   = stage_reg;
        weight_next  = weight_reg;
        if (cfg_we && (cfg_index == fcmv_pkg::REG_INPUT_LENGTH))
        begin
            in_lim_next = in_limit(cfg_data);
        end
        if (cfg_we && (cfg_index == fcmv_pkg::REG_OUTPUT_LENGTH))
        begin
            out_lim_next = out_limit(cfg_data);
        end
        if (!hold)
        begin
            stage_next.valid     = w_acc;
            stage_next.eor       = eor;
            stage_next.out_index = fcmv_pkg::IDX_W'(row_reg);
            stage_next.last      = last_row;
            weight_next          = item.value;
        end
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (w_acc)
        begin
            if (eor)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_lim_reg  <= in_limit(fcmv_pkg::CFG_W'(1024));
            out_lim_reg <= out_limit(fcmv_pkg::CFG_W'(1024));
            col_reg     <= '0;
            row_reg     <= '0;
            stage_reg   <= '0;
        end
        else
        begin
            in_lim_reg  <= in_lim_next;
            out_lim_reg <= out_lim_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            stage_reg   <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign stage  = stage_reg;
    assign weight = weight_reg;

endmodule

>>> hw/rtl/fcmv_mac.sv
// multiply-accumulate and result register
// depends on fcmv_pkg
`timescale 1ns / 1ps

module fcmv_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  fcmv_pkg::stage_t                  stage,
    input  logic signed [fcmv_pkg::VAL_W-1:0] weight,
    input  logic signed [fcmv_pkg::VAL_W-1:0] act,
    input  logic                              result_stall,
    output logic                              hold,
    output logic                              result_valid,
    output fcmv_pkg::result_t                 result
);

    logic signed [fcmv_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic                              result_valid_reg, result_valid_next;
    fcmv_pkg::result_t                 result_reg, result_next;

    logic signed [fcmv_pkg::PROD_W-1:0] prod;
    logic signed [fcmv_pkg::SUM_W-1:0]  mac_sum;
    logic                               go;

    // a finished row waits while the result register is full and stalled
    assign hold    = stage.valid && stage.eor && result_valid_reg && result_stall;
    assign go      = stage.valid && !hold;
    assign prod    = act * weight;
    assign mac_sum = acc_reg + fcmv_pkg::SUM_W'(prod);

    always_comb
    begin
        acc_next          = acc_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (restart)
        begin
            acc_next = '0;
        end
        else if (go)
        begin
            if (stage.eor)
            begin
                result_valid_next     = 1'b1;
                result_next.out_index = stage.out_index;
                result_next.sum       = mac_sum;
                result_next.last      = stage.last;
                acc_next              = '0;
            end
            else
            begin
                acc_next = mac_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg          <= acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/fully_connected_matvec.sv
// a weight that ends a row is registered in the read stage, and its sum then shows in the result register
// throughput: one item per cycle while item_stall is low, activations and weights alike, set by the one
// store read and one multiply-accumulate per cycle
// item_stall rises only while a finished row waits behind a full, stalled result
// reset: lengths 1024 (clamped to MAX_INPUTS and MAX_OUTPUTS), counters and accumulator zero;
// the activation store is not cleared and holds nothing until written
`timescale 1ns / 1ps
`include "fully_connected_matvec_macros.svh"

module fully_connected_matvec #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  fcmv_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output fcmv_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [fcmv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcmv_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_INPUTS);

    // front end to memory
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [fcmv_pkg::VAL_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [fcmv_pkg::VAL_W-1:0] rd_data;

    // read stage to multiply-accumulate
    fcmv_pkg::stage_t                  stage;
    logic signed [fcmv_pkg::VAL_W-1:0] weight;
    logic                              hold;
    logic                              restart;

    // the only back pressure is a finished row that cannot leave
    assign item_stall = hold;

    // counters advance at accept time, the weight reads its activation at once
    fcmv_seq #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hold       (hold),
        .restart    (restart),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .stage      (stage),
        .weight     (weight)
    );

    // one item per cycle never reads and writes in the same edge,
    // and a write is visible to any later read, so no forwarding
    fcmv_act_mem #(
        .DEPTH (MAX_INPUTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // product of read data and held weight, added into the row sum
    fcmv_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .stage        (stage),
        .weight       (weight),
        .act          (rd_data),
        .result_stall (result_stall),
        .hold         (hold),
        .result_valid (result_valid),
        .result       (result)
    );

    // a row that ends and moves on lands in the result register
    `FCMV_ASSERT_NEXT(a_row_result, stage.valid && stage.eor && !hold,
        result_valid && (result.out_index == $past(stage.out_index)),
        "finished row did not reach the result register")

    // a weight that ends its row is marked in the read stage
    `FCMV_ASSERT_NEXT(a_eor_stage,
        item_valid && !item_stall && item.kind && (rd_addr == u_seq.in_lim_reg),
        stage.valid && stage.eor, "end of row lost in the read stage")

    // input stall only while the result is full and stalled
    `FCMV_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall,
        "input stalled without a blocked result")

endmodule
